### sv/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared widths, command and status codes for the connection match table.
// ----------------------------------------------------------------------------
package cmt_pkg;
  localparam int PEER_COUNT_D    = 16;
  localparam int ENTRY_COUNT_D   = 32;
  localparam int ADDRESS_BITS_D  = 64;
  localparam int SEQUENCE_BITS_D = 16;
  localparam int HANDLE_BITS_D   = 8;

  localparam logic [1:0] CMD_NEXT   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_SENTINEL     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
  localparam logic [2:0] ST_PEERS_FULL   = 3'd3;
  localparam logic [2:0] ST_ENTRIES_FULL = 3'd4;

  localparam logic REG_MAX_SEQ  = 1'b0;
  localparam logic REG_ADDR_BYT = 1'b1;
endpackage

### sv/cmt_if.sv
// ----------------------------------------------------------------------------
// cmt_in_if / cmt_out_if
// Valid/ready channels for command and result beats.
// ----------------------------------------------------------------------------
interface cmt_in_if #(
  parameter int ADDRESS_BITS  = cmt_pkg::ADDRESS_BITS_D,
  parameter int SEQUENCE_BITS = cmt_pkg::SEQUENCE_BITS_D,
  parameter int HANDLE_BITS   = cmt_pkg::HANDLE_BITS_D
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [ADDRESS_BITS-1:0]  peer_address;
  logic [SEQUENCE_BITS-1:0] conn_sequence;
  logic [HANDLE_BITS-1:0]   elem_handle;
  logic [1:0]               queue_select;
  logic                     delete_on_match;
  modport source (output valid, command, peer_address, conn_sequence, elem_handle,
                  queue_select, delete_on_match, input ready);
  modport sink (input valid, command, peer_address, conn_sequence, elem_handle,
                queue_select, delete_on_match, output ready);
endinterface

interface cmt_out_if #(
  parameter int SEQUENCE_BITS = cmt_pkg::SEQUENCE_BITS_D,
  parameter int HANDLE_BITS   = cmt_pkg::HANDLE_BITS_D
);
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic [SEQUENCE_BITS-1:0] sequence_out;
  logic                     found;
  logic [HANDLE_BITS-1:0]   matched_handle;
  modport source (output valid, status, sequence_out, found, matched_handle,
                  input ready);
  modport sink (input valid, status, sequence_out, found, matched_handle,
                output ready);
endinterface

### sv/connection_match_table_top.sv
// ----------------------------------------------------------------------------
// connection_match_table_top
// Per-peer table of expected and unexpected connection handles.
// ----------------------------------------------------------------------------
// Sequence: a lookup or remove walks the peer table, then the entry store; a lookup
//   walks the entry store again when it searches both queues, and an insert walks
//   the peer table, then allocates a free entry; one shared compare unit walks
//   the peer table, then the entry store, one slot per cycle.
// Throughput: one beat in flight; the next command waits for the result beat.
// Reset: clears peer and entry valid bits, insert counter and registers.
module connection_match_table_top #(
  parameter int PEER_COUNT    = cmt_pkg::PEER_COUNT_D,
  parameter int ENTRY_COUNT   = cmt_pkg::ENTRY_COUNT_D,
  parameter int ADDRESS_BITS  = cmt_pkg::ADDRESS_BITS_D,
  parameter int SEQUENCE_BITS = cmt_pkg::SEQUENCE_BITS_D,
  parameter int HANDLE_BITS   = cmt_pkg::HANDLE_BITS_D
) (
  input  logic        clk,
  input  logic        rst,
  cmt_in_if.sink      in_ch,
  cmt_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int PW = $clog2(PEER_COUNT);
  localparam int EW = $clog2(ENTRY_COUNT);
  localparam int IW = ((PW > EW) ? PW : EW) + 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_PEER = 3'd1, S_ALLOC = 3'd2,
                         S_SCAN = 3'd3, S_DONE = 3'd4, S_OUT = 3'd5;

  logic [SEQUENCE_BITS-1:0] max_sequence;
  logic [3:0]               address_bytes;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_sequence  <= SEQUENCE_BITS'(16'hFFFF);
      address_bytes <= 4'd8;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == cmt_pkg::REG_MAX_SEQ) max_sequence <= SEQUENCE_BITS'(pwdata[15:0]);
      else address_bytes <= pwdata[3:0];
    end
  end
  always_comb begin
    if (paddr[2] == cmt_pkg::REG_ADDR_BYT) prdata = {28'd0, address_bytes};
    else prdata = 32'(max_sequence);
  end

  logic [2:0]               state;
  logic [1:0]               cmd;
  logic [ADDRESS_BITS-1:0]  key;
  logic [SEQUENCE_BITS-1:0] seq;
  logic [HANDLE_BITS-1:0]   hdl;
  logic [1:0]               qsel;
  logic                     del;
  logic                     cur_q;
  logic [IW-1:0]            idx;
  logic                     pfound, phole;
  logic [PW-1:0]            pidx, phidx;
  logic                     efound;
  logic [EW-1:0]            eidx;
  logic [31:0]              edist;
  logic [31:0]              insert_counter;

  logic [PEER_COUNT-1:0]    peer_valid;
  logic [ADDRESS_BITS-1:0]  peer_key [PEER_COUNT];
  logic [SEQUENCE_BITS-1:0] peer_seq [PEER_COUNT];
  logic [ENTRY_COUNT-1:0]   entry_valid;
  logic [PW-1:0]            entry_peer [ENTRY_COUNT];
  logic                     entry_queue [ENTRY_COUNT];
  logic [SEQUENCE_BITS-1:0] entry_sequence [ENTRY_COUNT];
  logic [HANDLE_BITS-1:0]   entry_handle [ENTRY_COUNT];
  logic [31:0]              entry_age [ENTRY_COUNT];

  logic [2:0]               o_status;
  logic [SEQUENCE_BITS-1:0] o_seq;
  logic                     o_found;
  logic [HANDLE_BITS-1:0]   o_hdl;

  // key mask from address_bytes
  logic [ADDRESS_BITS-1:0] kmask;
  always_comb begin
    logic [63:0] m;
    case (address_bytes)
      4'd0: m = 64'd0;
      4'd1: m = 64'hFF;
      4'd2: m = 64'hFFFF;
      4'd3: m = 64'hFF_FFFF;
      4'd4: m = 64'hFFFF_FFFF;
      4'd5: m = 64'hFF_FFFF_FFFF;
      4'd6: m = 64'hFFFF_FFFF_FFFF;
      4'd7: m = 64'hFF_FFFF_FFFF_FFFF;
      default: m = '1;
    endcase
    kmask = m[ADDRESS_BITS-1:0];
  end

  // shared compare unit, one slot per cycle
  logic [PW-1:0] pi;
  logic [EW-1:0] ei;
  logic          pmatch, ematch;
  logic [31:0]   gap;
  logic          lookup_sentinel;
  assign pi = idx[PW-1:0];
  assign ei = idx[EW-1:0];
  assign pmatch = peer_valid[pi] && peer_key[pi] == key;
  assign gap = insert_counter - entry_age[ei];
  assign ematch = entry_valid[ei] && entry_peer[ei] == pidx && entry_queue[ei] == cur_q &&
                  entry_sequence[ei] == seq &&
                  (cmd != cmt_pkg::CMD_REMOVE || entry_handle[ei] == hdl);
  assign lookup_sentinel = in_ch.command == cmt_pkg::CMD_LOOKUP &&
                           in_ch.conn_sequence == max_sequence;

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.status = o_status;
  assign out_ch.sequence_out = o_seq;
  assign out_ch.found = o_found;
  assign out_ch.matched_handle = o_hdl;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      peer_valid <= '0;
      entry_valid <= '0;
      insert_counter <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) begin
          cmd  <= in_ch.command;
          key  <= in_ch.peer_address & kmask;
          seq  <= in_ch.conn_sequence;
          hdl  <= in_ch.elem_handle;
          qsel <= in_ch.queue_select;
          del  <= in_ch.delete_on_match;
          idx <= '0; pfound <= 1'b0; phole <= 1'b0;
          o_seq <= '0; o_found <= 1'b0; o_hdl <= '0;
          o_status <= lookup_sentinel ? cmt_pkg::ST_SENTINEL : cmt_pkg::ST_OK;
          if (lookup_sentinel) state <= S_OUT;
          else state <= S_PEER;
        end
        S_PEER: begin
          if (!pfound && pmatch) begin pfound <= 1'b1; pidx <= pi; end
          if (!phole && !peer_valid[pi]) begin phole <= 1'b1; phidx <= pi; end
          if (idx == IW'(PEER_COUNT - 1)) begin
            idx <= '0; efound <= 1'b0; edist <= '0;
            cur_q <= (cmd == cmt_pkg::CMD_LOOKUP && qsel[1]) ? 1'b0 : qsel[0];
            state <= S_DONE;
          end else idx <= idx + 1'b1;
        end
        S_DONE: begin
          // resolve peer and decide next phase
          if (cmd == cmt_pkg::CMD_NEXT || cmd == cmt_pkg::CMD_INSERT) begin
            if (!pfound) begin
              if (!phole) begin
                o_status <= cmt_pkg::ST_PEERS_FULL;
                state <= S_OUT;
              end else begin
                peer_valid[phidx] <= 1'b1;
                peer_key[phidx] <= key;
                peer_seq[phidx] <= '0;
                pidx <= phidx;
                pfound <= 1'b1;
              end
            end else if (cmd == cmt_pkg::CMD_NEXT) begin
              o_seq <= peer_seq[pidx];
              if (peer_seq[pidx] == max_sequence) o_status <= cmt_pkg::ST_SENTINEL;
              else peer_seq[pidx] <= peer_seq[pidx] + 1'b1;
              state <= S_OUT;
            end else if (seq == max_sequence) begin
              o_status <= cmt_pkg::ST_SENTINEL;
              state <= S_OUT;
            end else begin
              idx <= '0;
              state <= S_ALLOC;
            end
          end else if (!pfound) begin
            o_status <= cmt_pkg::ST_NOT_FOUND;
            state <= S_OUT;
          end else begin
            idx <= '0;
            state <= S_SCAN;
          end
        end
        S_ALLOC: begin
          if (!entry_valid[ei]) begin
            entry_valid[ei] <= 1'b1;
            entry_peer[ei] <= pidx;
            entry_queue[ei] <= qsel[0];
            entry_sequence[ei] <= seq;
            entry_handle[ei] <= hdl;
            entry_age[ei] <= insert_counter;
            insert_counter <= insert_counter + 1'b1;
            o_found <= 1'b1;
            state <= S_OUT;
          end else if (idx == IW'(ENTRY_COUNT - 1)) begin
            o_status <= cmt_pkg::ST_ENTRIES_FULL;
            state <= S_OUT;
          end else idx <= idx + 1'b1;
        end
        S_SCAN: begin
          logic hit;
          logic [EW-1:0] bi;
          hit = efound;
          bi = eidx;
          if (ematch && (!efound || gap > edist)) begin
            hit = 1'b1; bi = ei;
            efound <= 1'b1; eidx <= ei; edist <= gap;
          end
          if (idx == IW'(ENTRY_COUNT - 1)) begin
            idx <= '0;
            if (!hit && cmd == cmt_pkg::CMD_LOOKUP && qsel[1] && !cur_q) begin
              cur_q <= 1'b1;
            end else begin
              state <= S_OUT;
              if (!hit) o_status <= cmt_pkg::ST_NOT_FOUND;
              else if (cmd == cmt_pkg::CMD_REMOVE) entry_valid[bi] <= 1'b0;
              else begin
                o_found <= 1'b1;
                o_hdl <= entry_handle[bi];
                if (del) entry_valid[bi] <= 1'b0;
              end
            end
          end else idx <= idx + 1'b1;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
